/* src/keyword_command_recognizer_assert.svh */
// Assertion helpers shared by the recognizer modules.
// Each macro checks a property on the rising clock edge and is switched
// off while the active-low reset is asserted.
`ifndef KEYWORD_COMMAND_RECOGNIZER_ASSERT_SVH
`define KEYWORD_COMMAND_RECOGNIZER_ASSERT_SVH

// Same-cycle implication.
`define KCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyword_command_recognizer: assertion failed");

// Next-cycle implication.
`define KCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyword_command_recognizer: assertion failed");

`endif

/* src/kcr_pkg.sv */
`timescale 1ns / 1ps

package kcr_pkg;

    localparam int KW_COUNT = 11;

    localparam logic [2:0] POS_MAX = 3'd7;

    localparam logic [KW_COUNT-1:0] KW_ALL_ALIVE = {KW_COUNT{1'b1}};

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Command codes.
    localparam logic [2:0] CMD_UP          = 3'd0;
    localparam logic [2:0] CMD_DESCEND     = 3'd1;
    localparam logic [2:0] CMD_HALT        = 3'd2;
    localparam logic [2:0] CMD_BRAKE_APPLY = 3'd3;
    localparam logic [2:0] CMD_BRAKE_FREE  = 3'd4;
    localparam logic [2:0] CMD_CALIBRATE   = 3'd5;

    // Keyword text in priority order, padded with NUL to eight characters.
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"u", "p", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"s", "u", "b", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"d", "o", "w", "n", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"d", "e", "s", "c", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"s", "t", "o", "p", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"p", "a", "r", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"b", "r", "a", "k", "e", CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"f", "r", "e", "i", "o", CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"r", "e", "l", "e", "a", "s", "e", CHAR_NUL},
        '{"s", "o", "l", "t", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
        '{"c", "a", "l", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5, 3'd7, 3'd4, 3'd3
    };

    localparam logic [2:0] KW_CMD [KW_COUNT] = '{
        CMD_UP, CMD_UP, CMD_DESCEND, CMD_DESCEND, CMD_HALT, CMD_HALT,
        CMD_BRAKE_APPLY, CMD_BRAKE_APPLY, CMD_BRAKE_FREE, CMD_BRAKE_FREE, CMD_CALIBRATE
    };

    typedef struct packed {
        logic       valid;
        logic [2:0] command;
    } t_result;

endpackage

/* src/kcr_match.sv */
`timescale 1ns / 1ps
`include "keyword_command_recognizer_assert.svh"

module kcr_match import kcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    logic [KW_COUNT-1:0] r_alive;
    logic [KW_COUNT-1:0] n_alive;
    logic [2:0]          r_pos;
    logic [2:0]          n_pos;
    logic                r_nonempty;
    logic                n_nonempty;
    logic [7:0]          ch;
    logic                is_eol;
    logic                found;

    always_comb begin
        ch = i_byte;
        if (i_byte >= "A" && i_byte <= "Z") begin
            ch = i_byte | 8'h20;
        end
        is_eol     = (i_byte == CHAR_LF) || (i_byte == CHAR_CR);
        n_alive    = r_alive;
        n_pos      = r_pos;
        n_nonempty = r_nonempty;
        found      = 1'b0;
        o_result   = '0;

        if (is_eol) begin
            if (r_nonempty) begin
                // The first keyword still alive and fully seen wins.
                for (int i = 0; i < KW_COUNT; i++) begin
                    if (!found && r_alive[i] && (r_pos >= KW_LEN[i])) begin
                        found            = 1'b1;
                        o_result.command = KW_CMD[i];
                    end
                end
                o_result.valid = found;
                n_alive        = KW_ALL_ALIVE;
                n_pos          = '0;
                n_nonempty     = 1'b0;
            end
        end else begin
            n_nonempty = 1'b1;
            if (r_pos != POS_MAX) begin
                for (int i = 0; i < KW_COUNT; i++) begin
                    if ((r_pos < KW_LEN[i]) && (KW_TEXT[i][r_pos] != ch)) begin
                        n_alive[i] = 1'b0;
                    end
                end
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive    <= KW_ALL_ALIVE;
            r_pos      <= '0;
            r_nonempty <= 1'b0;
        end else if (i_step) begin
            r_alive    <= n_alive;
            r_pos      <= n_pos;
            r_nonempty <= n_nonempty;
        end
    end

    // A line holds bytes exactly when the position counter has moved.
    `KCR_ASSERT_IMP(a_nonempty_pos, i_clk, i_rst_n, 1'b1, r_nonempty == (r_pos != 3'd0))
    // No keyword can be ruled out before the first byte of a line.
    `KCR_ASSERT_IMP(a_fresh_alive, i_clk, i_rst_n, r_pos == 3'd0, r_alive == KW_ALL_ALIVE)
    // Ending a non-empty line returns the line state to its start.
    `KCR_ASSERT_NXT(a_eol_clear, i_clk, i_rst_n, i_step && is_eol && r_nonempty,
        r_pos == 3'd0 && !r_nonempty)

endmodule

/* src/kcr_out.sv */
`timescale 1ns / 1ps

module kcr_out import kcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [2:0] o_command
);

    logic       r_valid;
    logic [2:0] r_command;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_command <= i_result.command;
        end
    end

    assign o_valid   = r_valid;
    assign o_command = r_command;

endmodule

/* src/keyword_command_recognizer.sv */
// Keyword command recognizer.
// Input channel: one received text byte per transaction on i_rx_byte, with
// i_in_valid / o_in_ready. Letters are folded to lower case, and LF or CR
// ends a line. A non-empty line that starts with one of the known keywords
// yields one command transaction on o_command (o_out_valid / i_out_ready);
// empty and unmatched lines yield nothing.
// An accepted byte sits in the input register and is evaluated there; its
// command, if any, is loaded into the output register once that register is
// free, and the receiver takes it from there.
// Throughput: one byte per cycle while the output side keeps up; the only
// limit is the single output register.
// Reset (i_rst_n low, synchronous) empties both registers and restarts the
// line state with every keyword still possible.
// When the receiver stalls with a command waiting, the byte in the input
// register waits too and o_in_ready drops; no transaction is lost.
`timescale 1ns / 1ps
`include "keyword_command_recognizer_assert.svh"

module keyword_command_recognizer import kcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_command
);

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // The held byte is consumed when the output register can take a result.
    logic       out_free;
    logic       advance;
    t_result    result;

    assign out_free   = !o_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Per-line keyword tracking and command selection.
    kcr_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // Result register toward the receiver.
    kcr_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (advance),
        .i_result  (result),
        .i_ready   (i_out_ready),
        .o_valid   (o_out_valid),
        .o_command (o_command)
    );

    // An empty output register never holds back the input side.
    `KCR_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // A command found for the held byte shows up at the output next cycle.
    `KCR_ASSERT_NXT(a_result_lands, i_clk, i_rst_n, advance && result.valid, o_out_valid)
    // A held byte is consumed whenever the receiver takes the pending command.
    `KCR_ASSERT_IMP(a_drain_moves, i_clk, i_rst_n, r_in_valid && o_out_valid && i_out_ready,
        advance)

endmodule
